FILE: design/mcd_pkg.sv
// ----------------------------------------------------------------------------
// mcd_pkg: shared types for the close-detection merge block
// Word formats for the input and result channels, the stored detection
// entry, and the control group for the shared squaring unit.
// ----------------------------------------------------------------------------
package mcd_pkg;

	// one detection as it arrives
	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [3:0]         object_id;
		logic signed [15:0] heading;
		logic               last_in_set;
	} det_word_t;

	// one surviving detection as it leaves
	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic [3:0]         out_id;
		logic signed [15:0] out_heading;
		logic               out_last;
		logic               overflow;
	} mrg_word_t;

	// one entry of the detection store
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [3:0]         id;
		logic signed [15:0] hd;
	} entry_t;

	localparam int CoordW = 16;
	localparam int SqW    = 2 * CoordW;
	localparam int AccW   = SqW + 1;
	localparam int DistW  = 15;

	// control of the shared squaring unit
	typedef struct packed {
		logic sq_en;     // register operand squared
		logic acc_load;  // accumulator takes the last square
		logic acc_add;   // accumulator adds the last square
	} sq_ctl_t;

endpackage

FILE: design/mcd_sqacc.sv
// ----------------------------------------------------------------------------
// mcd_sqacc: shared squaring unit with accumulator
// One 16x16 unsigned multiplier used for the squared merge radius and for
// both squared coordinate differences; a 33-bit accumulator forms dx^2+dy^2.
// ----------------------------------------------------------------------------
module mcd_sqacc (
	input  logic                  clk,
	input  mcd_pkg::sq_ctl_t      ctl,
	input  logic [15:0]           operand,
	output logic [31:0]           square,
	output logic [32:0]           acc
);
	import mcd_pkg::*;

	logic [SqW-1:0]  sq_q;
	logic [AccW-1:0] acc_q;

	// registered square
	always_ff @(posedge clk) begin
		if (ctl.sq_en) begin
			sq_q <= operand * operand;
		end
	end

	// sum of squares
	always_ff @(posedge clk) begin
		if (ctl.acc_load) begin
			acc_q <= {1'b0, sq_q};
		end else if (ctl.acc_add) begin
			acc_q <= acc_q + {1'b0, sq_q};
		end
	end

	assign square = sq_q;
	assign acc    = acc_q;

endmodule

FILE: design/merge_close_detections_unit.sv
// ----------------------------------------------------------------------------
// merge_close_detections_unit: merges close detections of one frame
// Collects a frame's detections, merges pairs closer than the merge radius
// and sends the survivors out in store order.
// ----------------------------------------------------------------------------
// Usage:
//   det channel (det_valid/det_stall/det): one detection word per handshake.
//   A word without last_in_set is stored and gives no result.
//   Words beyond MAX_DETECTIONS are dropped and flag overflow on the set.
//   A word with last_in_set starts the merge pass; det_stall stays high
//   until the last survivor has been taken on the mrg channel.
//   mrg channel (mrg_valid/mrg_stall/mrg): one survivor word per handshake,
//   out_last on the final one. A stall simply holds the word and the pass.
//   Steps of a set: the squared radius is formed first, then each kept
//   entry is read and tested against each later entry (difference, squares,
//   sum, compare); an absorbed entry is overwritten by the last entry, and
//   a final check closes the pass; then each survivor is read and sent.
//   All of it is paced by the single squaring unit and the one-read,
//   one-write port of the detection store.
//   The merge radius register is written from cfg_data when cfg_we is high.
//   Reset clears the entry count, the overflow flag and the sequencer;
//   the store contents need no clearing, only written entries are read.
// ----------------------------------------------------------------------------
module merge_close_detections_unit #(
	parameter int MAX_DETECTIONS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [14:0]        cfg_data,
	input  logic               det_valid,
	output logic               det_stall,
	input  mcd_pkg::det_word_t det,
	output logic               mrg_valid,
	input  logic               mrg_stall,
	output mcd_pkg::mrg_word_t mrg
);
	import mcd_pkg::*;

	localparam int AW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
	localparam int CW = $clog2(MAX_DETECTIONS + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LIM_SQ = 4'd1;
	localparam logic [3:0] ST_LIM_SV = 4'd2;
	localparam logic [3:0] ST_I_RD   = 4'd3;
	localparam logic [3:0] ST_I_LD   = 4'd4;
	localparam logic [3:0] ST_J_CHK  = 4'd5;
	localparam logic [3:0] ST_J_DIFF = 4'd6;
	localparam logic [3:0] ST_J_SQX  = 4'd7;
	localparam logic [3:0] ST_J_SQY  = 4'd8;
	localparam logic [3:0] ST_J_ADD  = 4'd9;
	localparam logic [3:0] ST_J_CMP  = 4'd10;
	localparam logic [3:0] ST_MV_LD  = 4'd11;
	localparam logic [3:0] ST_EM_RD  = 4'd12;
	localparam logic [3:0] ST_EM_LD  = 4'd13;
	localparam logic [3:0] ST_EM_OUT = 4'd14;

	logic [3:0]        state_q;
	logic [DistW-1:0]  dist_q;
	logic [CW-1:0]     count_q;
	logic              dropped_q;
	logic [CW-1:0]     n_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     j_q;
	logic [CW-1:0]     nm1;
	logic [SqW-1:0]    lim_q;
	entry_t            ent_i_q;
	logic signed [15:0] xj_q;
	logic signed [15:0] yj_q;
	logic [15:0]       adx_q;
	logic [15:0]       ady_q;
	logic              mrg_valid_q;
	mrg_word_t         mrg_q;

	// detection store
	entry_t            mem [MAX_DETECTIONS];
	entry_t            rd_q;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	entry_t            wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;

	// shared squaring unit
	sq_ctl_t           sq_ctl;
	logic [15:0]       sq_op;
	logic [SqW-1:0]    sq_res;
	logic [AccW-1:0]   acc_res;

	logic              det_acc;
	logic              full;
	logic [CW-1:0]     count_nx;
	logic signed [16:0] dx_w;
	logic signed [16:0] dy_w;
	logic signed [16:0] sx_w;
	logic signed [16:0] sy_w;

	assign det_acc  = det_valid && !det_stall;
	assign full     = (count_q == CW'(MAX_DETECTIONS));
	assign count_nx = full ? count_q : count_q + CW'(1);
	assign nm1      = n_q - CW'(1);

	// coordinate differences and sums against the entry just read
	assign dx_w = {ent_i_q.x[15], ent_i_q.x} - {rd_q.x[15], rd_q.x};
	assign dy_w = {ent_i_q.y[15], ent_i_q.y} - {rd_q.y[15], rd_q.y};
	assign sx_w = {ent_i_q.x[15], ent_i_q.x} + {xj_q[15], xj_q};
	assign sy_w = {ent_i_q.y[15], ent_i_q.y} + {yj_q[15], yj_q};

	mcd_sqacc u_sqacc (
		.clk     (clk),
		.ctl     (sq_ctl),
		.operand (sq_op),
		.square  (sq_res),
		.acc     (acc_res)
	);

	// squaring unit control
	always_comb begin
		sq_ctl   = '0;
		sq_op    = adx_q;
		case (state_q)
			ST_LIM_SQ: begin
				sq_ctl.sq_en = 1'b1;
				sq_op        = {1'b0, dist_q};
			end
			ST_J_SQX: begin
				sq_ctl.sq_en = 1'b1;
				sq_op        = adx_q;
			end
			ST_J_SQY: begin
				sq_ctl.sq_en    = 1'b1;
				sq_ctl.acc_load = 1'b1;
				sq_op           = ady_q;
			end
			ST_J_ADD: begin
				sq_ctl.acc_add = 1'b1;
			end
			default: begin
				sq_ctl = '0;
			end
		endcase
	end

	// store port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = '{x: det.pos_x, y: det.pos_y, id: det.object_id, hd: det.heading};
		rd_en   = 1'b0;
		rd_addr = i_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				wr_en = det_acc && !full;
			end
			ST_I_RD: begin
				rd_en   = (i_q < n_q);
				rd_addr = i_q[AW-1:0];
			end
			ST_J_CHK: begin
				if (j_q < n_q) begin
					rd_en   = 1'b1;
					rd_addr = j_q[AW-1:0];
				end else begin
					wr_en   = 1'b1;
					wr_addr = i_q[AW-1:0];
					wr_data = ent_i_q;
				end
			end
			ST_J_CMP: begin
				rd_en   = (acc_res < {1'b0, lim_q});
				rd_addr = nm1[AW-1:0];
			end
			ST_MV_LD: begin
				wr_en   = 1'b1;
				wr_addr = j_q[AW-1:0];
				wr_data = rd_q;
			end
			ST_EM_RD: begin
				rd_en   = 1'b1;
				rd_addr = i_q[AW-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// store array, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// merge radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= DistW'(100);
		end else if (cfg_we) begin
			dist_q <= cfg_data;
		end
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			mrg_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (det_acc) begin
						count_q   <= count_nx;
						dropped_q <= dropped_q | full;
						if (det.last_in_set) begin
							n_q     <= count_nx;
							i_q     <= '0;
							state_q <= ST_LIM_SQ;
						end
					end
				end
				ST_LIM_SQ: begin
					state_q <= ST_LIM_SV;
				end
				ST_LIM_SV: begin
					state_q <= ST_I_RD;
				end
				ST_I_RD: begin
					if (i_q < n_q) begin
						state_q <= ST_I_LD;
					end else begin
						i_q     <= '0;
						state_q <= (n_q == '0) ? ST_IDLE : ST_EM_RD;
						if (n_q == '0) begin
							count_q   <= '0;
							dropped_q <= 1'b0;
						end
					end
				end
				ST_I_LD: begin
					j_q     <= i_q + CW'(1);
					state_q <= ST_J_CHK;
				end
				ST_J_CHK: begin
					if (j_q < n_q) begin
						state_q <= ST_J_DIFF;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= ST_I_RD;
					end
				end
				ST_J_DIFF: begin
					state_q <= ST_J_SQX;
				end
				ST_J_SQX: begin
					state_q <= ST_J_SQY;
				end
				ST_J_SQY: begin
					state_q <= ST_J_ADD;
				end
				ST_J_ADD: begin
					state_q <= ST_J_CMP;
				end
				ST_J_CMP: begin
					if (acc_res < {1'b0, lim_q}) begin
						state_q <= ST_MV_LD;
					end else begin
						j_q     <= j_q + CW'(1);
						state_q <= ST_J_CHK;
					end
				end
				ST_MV_LD: begin
					n_q     <= nm1;
					state_q <= ST_J_CHK;
				end
				ST_EM_RD: begin
					state_q <= ST_EM_LD;
				end
				ST_EM_LD: begin
					mrg_valid_q <= 1'b1;
					state_q     <= ST_EM_OUT;
				end
				ST_EM_OUT: begin
					if (!mrg_stall) begin
						mrg_valid_q <= 1'b0;
						if (i_q == nm1) begin
							count_q   <= '0;
							dropped_q <= 1'b0;
							state_q   <= ST_IDLE;
						end else begin
							i_q     <= i_q + CW'(1);
							state_q <= ST_EM_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// merge datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LIM_SV: begin
				lim_q <= sq_res;
			end
			ST_I_LD: begin
				ent_i_q <= rd_q;
			end
			ST_J_DIFF: begin
				xj_q  <= rd_q.x;
				yj_q  <= rd_q.y;
				adx_q <= dx_w[16] ? 16'(-dx_w) : dx_w[15:0];
				ady_q <= dy_w[16] ? 16'(-dy_w) : dy_w[15:0];
			end
			ST_J_CMP: begin
				if (acc_res < {1'b0, lim_q}) begin
					ent_i_q.x <= sx_w[16:1];
					ent_i_q.y <= sy_w[16:1];
				end
			end
			default: begin
				lim_q <= lim_q;
			end
		endcase
	end

	// result word register
	always_ff @(posedge clk) begin
		if (state_q == ST_EM_LD) begin
			mrg_q.out_x       <= rd_q.x;
			mrg_q.out_y       <= rd_q.y;
			mrg_q.out_id      <= rd_q.id;
			mrg_q.out_heading <= rd_q.hd;
			mrg_q.out_last    <= (i_q == nm1);
			mrg_q.overflow    <= dropped_q;
		end
	end

	assign det_stall = (state_q != ST_IDLE);
	assign mrg_valid = mrg_valid_q;
	assign mrg       = mrg_q;

endmodule
